FILE: sv/qph_pkg.sv
// Shared package for the quadratic probe hash table.
// Field widths, request and status codes, register indexes and the probe sequencer status type.
// No dependencies; every other file of the block but qph_ram imports it.
package qph_pkg;

  // Field and storage widths.
  localparam int KEY_W  = 31;
  localparam int SLOT_W = KEY_W + 1;
  localparam int CFG_W  = 7;
  localparam int POS_W  = 7;
  localparam int CNT_W  = 8;
  localparam int STS_W  = 2;

  // Request kinds.
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_FIND   = 1'b1;

  // Result status codes.
  localparam logic [STS_W-1:0] ST_INSERTED  = 2'd0;
  localparam logic [STS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STS_W-1:0] ST_FOUND     = 2'd2;
  localparam logic [STS_W-1:0] ST_NOT_FOUND = 2'd3;

  // Configuration register indexes.
  localparam logic REG_TABLE_LENGTH = 1'b0;
  localparam logic REG_HASH_MODULUS = 1'b1;

  // Status of the probe address sequencer.
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             done;
  } qph_gen_t;

endpackage

FILE: sv/qph_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module qph_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/qph_div.sv
// Multicycle modulo unit: key modulo a 7-bit divisor, four dividend bits per cycle.
// Depends on qph_pkg for the key and register widths.
module qph_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [qph_pkg::KEY_W-1:0]  dividend,
  input  logic [qph_pkg::CFG_W-1:0]  divisor,
  output logic                       done,
  output logic [qph_pkg::CFG_W-1:0]  remainder
);
  import qph_pkg::*;

  localparam int DIGITS = 4;
  localparam int PAD_W  = ((KEY_W + DIGITS - 1) / DIGITS) * DIGITS;
  localparam int STEPS  = PAD_W / DIGITS;
  localparam int STEP_W = $clog2(STEPS);

  logic [PAD_W-1:0]  shreg;
  logic [CFG_W-1:0]  rem_next;
  logic [STEP_W-1:0] step_cnt;
  logic              run;

  // Four restoring steps on the running remainder; it always stays below the divisor.
  always_comb begin
    logic [CFG_W:0] trial;
    rem_next = remainder;
    for (int j = 0; j < DIGITS; j++) begin
      trial = {rem_next, shreg[PAD_W-1-j]};
      if (trial >= {1'b0, divisor}) begin
        trial = trial - {1'b0, divisor};
      end
      rem_next = trial[CFG_W-1:0];
    end
  end

  // Control: run for STEPS steps, then pulse done.
  always_ff @(posedge clk) begin
    if (rst) begin
      run      <= 1'b0;
      done     <= 1'b0;
      step_cnt <= '0;
    end else begin
      done <= run && (step_cnt == STEP_W'(STEPS - 1));
      if (start) begin
        run      <= 1'b1;
        step_cnt <= '0;
      end else if (run) begin
        step_cnt <= step_cnt + 1'b1;
        if (step_cnt == STEP_W'(STEPS - 1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  // Datapath: dividend shifts out from the top, remainder accumulates.
  always_ff @(posedge clk) begin
    if (start) begin
      shreg     <= PAD_W'(dividend);
      remainder <= '0;
    end else if (run) begin
      shreg     <= shreg << DIGITS;
      remainder <= rem_next;
    end
  end

endmodule

FILE: sv/qph_probe_gen.sv
// Probe address sequencer: home slot, then home plus and minus i*i modulo the length.
// Squares are tracked incrementally modulo the length. Depends on qph_pkg.
module qph_probe_gen (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      step,
  input  logic [qph_pkg::POS_W-1:0] home,
  input  logic [qph_pkg::CFG_W-1:0] len,
  output qph_pkg::qph_gen_t         gen
);
  import qph_pkg::*;

  typedef enum logic [2:0] {
    PH_HOME  = 3'b001,
    PH_PLUS  = 3'b010,
    PH_MINUS = 3'b100
  } phase_t;

  phase_t           phase;
  logic [POS_W-1:0] home_r;
  logic [CFG_W-1:0] round;
  logic [CFG_W-1:0] sq;
  logic [CFG_W-1:0] delta;
  logic             done;
  logic [CFG_W:0]   sum_plus;
  logic [CFG_W:0]   sum_minus;
  logic [CFG_W:0]   sq_sum;
  logic [CFG_W:0]   delta_sum;
  logic [CFG_W-1:0] sq_next;
  logic [CFG_W-1:0] delta_next;
  logic [POS_W-1:0] pos;

  // Slot positions for both probe directions, each wrapped with one subtract.
  always_comb begin
    sum_plus  = {1'b0, home_r} + {1'b0, sq};
    sum_minus = {1'b0, home_r} + ({1'b0, len} - {1'b0, sq});
    if (sum_plus >= {1'b0, len}) begin
      sum_plus = sum_plus - {1'b0, len};
    end
    if (sum_minus >= {1'b0, len}) begin
      sum_minus = sum_minus - {1'b0, len};
    end
    case (phase)
      PH_HOME:  pos = home_r;
      PH_PLUS:  pos = sum_plus[POS_W-1:0];
      PH_MINUS: pos = sum_minus[POS_W-1:0];
      default:  pos = home_r;
    endcase
  end

  // Next square and next odd increment, both modulo the length.
  always_comb begin
    sq_sum    = {1'b0, sq} + {1'b0, delta};
    delta_sum = {1'b0, delta} + (CFG_W + 1)'(2);
    if (sq_sum >= {1'b0, len}) begin
      sq_sum = sq_sum - {1'b0, len};
    end
    if (delta_sum >= {1'b0, len}) begin
      delta_sum = delta_sum - {1'b0, len};
    end
    sq_next = sq_sum[CFG_W-1:0];
    if (len == CFG_W'(1)) begin
      delta_next = '0;
    end else begin
      delta_next = delta_sum[CFG_W-1:0];
    end
  end

  // Sequencer control: one position per step until the last round's minus probe.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HOME;
      done  <= 1'b1;
      round <= '0;
    end else if (start) begin
      phase <= PH_HOME;
      done  <= 1'b0;
      round <= '0;
    end else if (step && !done) begin
      case (phase)
        PH_PLUS: begin
          phase <= PH_MINUS;
        end
        PH_HOME, PH_MINUS: begin
          if (phase == PH_MINUS && round == len) begin
            done <= 1'b1;
          end else begin
            round <= round + 1'b1;
            phase <= PH_PLUS;
          end
        end
        default: begin
          phase <= PH_HOME;
        end
      endcase
    end
  end

  // Square tracking; starts at zero with increment one (zero for a length of one).
  always_ff @(posedge clk) begin
    if (start) begin
      home_r <= home;
      sq     <= '0;
      delta  <= (len == CFG_W'(1)) ? '0 : CFG_W'(1);
    end else if (step && !done && (phase == PH_HOME || phase == PH_MINUS)) begin
      sq    <= sq_next;
      delta <= delta_next;
    end
  end

  assign gen.pos  = pos;
  assign gen.done = done;

endmodule

FILE: sv/quadratic_probe_hash_table_unit.sv
// Top level of the quadratic probe hash table: control, slot checks, config and stream ports.
// Depends on qph_pkg, qph_ram, qph_div and qph_probe_gen.
//
//   Channel   Direction  Handshake                     Payload
//   s_axis    in         s_axis_tvalid/s_axis_tready   tuser: req_type; tdata: key_value
//   m_axis    out        m_axis_tvalid/m_axis_tready   tuser: status; tdata: slot, count
//   cfg       in         cfg_valid/cfg_ready           cfg_index, cfg_data
//
// One item at a time. The modulo unit first reduces the key (four key bits a cycle), then
// the slots of the probe sequence are compared one at a time through the RAM read port.
// After reset a clearing pass writes every slot empty before the first item is taken.
// A result waits in the output register; the next item may be taken meanwhile.
module quadratic_probe_hash_table_unit #(
  parameter int TABLE_SIZE = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  // Input items.
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [31:0]               s_axis_tdata,  // [30:0] key_value, [31] zero
  input  logic                      s_axis_tuser,  // [0] req_type
  // Result items.
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [15:0]               m_axis_tdata,  // [6:0] slot_position, [14:7] probe_count
  output logic [1:0]                m_axis_tuser,  // [1:0] status
  // Configuration writes.
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [qph_pkg::CFG_W-1:0] cfg_data
);
  import qph_pkg::*;

  localparam int AW     = $clog2(TABLE_SIZE);
  localparam int LenCap = (TABLE_SIZE < 127) ? TABLE_SIZE : 127;
  localparam logic [CFG_W-1:0] LEN_CAP = CFG_W'(LenCap);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_DIV   = 5'b00100,
    S_PROBE = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t            state;
  logic [AW-1:0]     clr_addr;
  logic [CFG_W-1:0]  table_length;
  logic [CFG_W-1:0]  hash_modulus;
  logic [CFG_W-1:0]  len_eff;
  logic [CFG_W-1:0]  mod_eff;
  logic [KEY_W-1:0]  key;
  logic              is_find;
  logic              in_accept;
  logic              div_done;
  logic [CFG_W-1:0]  home;
  qph_gen_t          gen;
  logic              gen_start;
  logic              gen_step;
  logic              rd_pend;
  logic [POS_W-1:0]  rd_pos;
  logic [CNT_W-1:0]  count;
  logic [SLOT_W-1:0] rdata;
  logic              slot_empty;
  logic              slot_hit;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [SLOT_W-1:0] ram_wdata;
  logic [STS_W-1:0]  res_status;
  logic [POS_W-1:0]  res_pos;
  logic [CNT_W-1:0]  res_count;
  logic              out_free;

  // Effective length and modulus after clamping.
  always_comb begin
    if (table_length == '0) begin
      len_eff = CFG_W'(1);
    end else if (table_length > LEN_CAP) begin
      len_eff = LEN_CAP;
    end else begin
      len_eff = table_length;
    end
    if (hash_modulus == '0) begin
      mod_eff = CFG_W'(1);
    end else if (hash_modulus > len_eff) begin
      mod_eff = len_eff;
    end else begin
      mod_eff = hash_modulus;
    end
  end

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_length <= CFG_W'(11);
      hash_modulus <= CFG_W'(11);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TABLE_LENGTH: table_length <= cfg_data;
        REG_HASH_MODULUS: hash_modulus <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // Home slot from the modulo unit.
  qph_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (in_accept),
    .dividend  (s_axis_tdata[KEY_W-1:0]),
    .divisor   (mod_eff),
    .done      (div_done),
    .remainder (home)
  );

  assign gen_start = (state == S_DIV) && div_done;
  assign gen_step  = (state == S_PROBE);

  qph_probe_gen u_gen (
    .clk   (clk),
    .rst   (rst),
    .start (gen_start),
    .step  (gen_step),
    .home  (POS_W'(home)),
    .len   (len_eff),
    .gen   (gen)
  );

  // Slot check on the read data of the previous cycle.
  assign slot_empty = !rdata[SLOT_W-1];
  assign slot_hit   = rdata[SLOT_W-1] && is_find && (rdata[KEY_W-1:0] == key);

  // RAM write port: clearing pass, or the insert into the first empty slot.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = '0;
    if (state == S_CLEAR) begin
      ram_we = 1'b1;
    end else if (state == S_PROBE && rd_pend && slot_empty && !is_find) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(rd_pos);
      ram_wdata = {1'b1, key};
    end
  end

  qph_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (TABLE_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (AW'(gen.pos)),
    .rdata (rdata)
  );

  // Main control sequence.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      rd_pend  <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(TABLE_SIZE - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rd_pend <= 1'b0;
          if (div_done) begin
            state <= S_PROBE;
          end
        end
        S_PROBE: begin
          rd_pend <= !gen.done;
          if (rd_pend && (slot_empty || slot_hit || gen.done)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Item registers and probe bookkeeping.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      key     <= s_axis_tdata[KEY_W-1:0];
      is_find <= s_axis_tuser;
    end
    if (gen_start) begin
      count <= '0;
    end else if (state == S_PROBE) begin
      rd_pos <= gen.pos;
      if (rd_pend) begin
        count <= count + 1'b1;
        if (slot_empty) begin
          res_status <= is_find ? ST_NOT_FOUND : ST_INSERTED;
          res_pos    <= is_find ? '0 : rd_pos + 1'b1;
          res_count  <= count + 1'b1;
        end else if (slot_hit) begin
          res_status <= ST_FOUND;
          res_pos    <= rd_pos + 1'b1;
          res_count  <= count + 1'b1;
        end else if (gen.done) begin
          res_status <= is_find ? ST_NOT_FOUND : ST_FULL;
          res_pos    <= '0;
          res_count  <= count + 1'b1;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_axis_tuser <= res_status;
      m_axis_tdata <= {1'b0, res_count, res_pos};
    end
  end

endmodule

FILE: test/quadratic_probe_hash_table_unit_tb.sv
// Self-checking testbench for quadratic_probe_hash_table_unit.
// Drives insert and find requests and table settings, and checks every result against a probe-walk predictor.
// Depends on qph_pkg and the RTL of the block.
module quadratic_probe_hash_table_unit_tb;
  import qph_pkg::*;

  localparam int TABLE_SIZE   = 64;
  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 7;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 160;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PHASE_ITEMS  = 110;
  localparam int PHASES       = 8;
  localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

  // One expected result item.
  typedef struct packed {
    logic [STS_W-1:0] status;
    logic [POS_W-1:0] slot;
    logic [CNT_W-1:0] count;
  } probe_result_t;

  logic              clk;
  logic              rst;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata;
  logic              s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [15:0]       m_axis_tdata;
  logic [1:0]        m_axis_tuser;
  logic              cfg_valid;
  logic              cfg_ready;
  logic              cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  // Mirror of the table contents and the two registers.
  logic              slot_used [TABLE_SIZE];
  logic [KEY_W-1:0]  slot_key [TABLE_SIZE];
  logic [CFG_W-1:0]  mirror_length;
  logic [CFG_W-1:0]  mirror_modulus;

  probe_result_t     pending_results[$];
  logic [KEY_W-1:0]  inserted_keys[$];

  int  mismatch_count = 0;
  int  requests_sent = 0;
  int  settings_used = 0;
  int  cycle_count = 0;
  int  status_seen [4] = '{0, 0, 0, 0};
  bit  quiet = 1'b0;
  logic hold_req = 1'b0;

  quadratic_probe_hash_table_unit #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Compare one slot; returns 1 when the slot ends the walk.
  function automatic bit visit_slot(input int unsigned idx, input logic req,
                                    input logic [KEY_W-1:0] key,
                                    output logic [STS_W-1:0] st);
    st = ST_INSERTED;
    if (!slot_used[idx]) begin
      if (req == REQ_FIND) begin
        st = ST_NOT_FOUND;
      end else begin
        slot_used[idx] = 1'b1;
        slot_key[idx]  = key;
      end
      return 1'b1;
    end
    if (req == REQ_FIND && slot_key[idx] == key) begin
      st = ST_FOUND;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Walk the quadratic probe sequence for one request and update the mirror.
  function automatic probe_result_t probe_table(input logic req, input logic [KEY_W-1:0] key);
    int unsigned      n;
    int unsigned      m;
    int unsigned      home;
    int unsigned      pos;
    int unsigned      off;
    int unsigned      cnt;
    logic [STS_W-1:0] st;
    bit               decided;
    probe_result_t    res;
    // Out-of-range register values are clamped as the hardware does.
    n = mirror_length;
    if (n < 1) n = 1;
    if (n > TABLE_SIZE) n = TABLE_SIZE;
    m = mirror_modulus;
    if (m < 1) m = 1;
    if (m > n) m = n;
    home = key % m;
    pos = home;
    cnt = 1;
    decided = visit_slot(home, req, key, st);
    for (int unsigned i = 1; i <= n && !decided; i++) begin
      off = (i * i) % n;
      pos = (home + off) % n;
      cnt++;
      decided = visit_slot(pos, req, key, st);
      if (!decided) begin
        pos = (home + n - off) % n;
        cnt++;
        decided = visit_slot(pos, req, key, st);
      end
    end
    // All rounds used up without an empty slot or a match.
    if (!decided) st = (req == REQ_FIND) ? ST_NOT_FOUND : ST_FULL;
    res.status = st;
    res.slot   = (st == ST_INSERTED || st == ST_FOUND) ? POS_W'(pos + 1) : '0;
    res.count  = CNT_W'(cnt);
    return res;
  endfunction

  // Half the keys are ones already inserted (once any exist), so finds hit and inserts duplicate; the rest is spread.
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5 && inserted_keys.size() != 0)
      return inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
    if (sel < 7) return KEY_W'($urandom_range(0, 200));
    if (sel < 9) return KEY_W'($urandom);
    return ($urandom_range(0, 1) == 1) ? KEY_MAX : '0;
  endfunction

  // Offer one request item and record its expected result once it is taken.
  task automatic offer_request(input logic req, input logic [KEY_W-1:0] key);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {1'b0, key};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_results.push_back(probe_table(req, key));
    if (req == REQ_INSERT) inserted_keys.push_back(key);
    requests_sent++;
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic settle_stream();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write both registers back to back; only called while no results are outstanding.
  task automatic write_geometry(input logic [CFG_W-1:0] len, input logic [CFG_W-1:0] modv);
    cfg_valid <= 1'b1;
    cfg_index <= REG_TABLE_LENGTH;
    cfg_data  <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    mirror_length = len;
    cfg_index <= REG_HASH_MODULUS;
    cfg_data  <= modv;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    mirror_modulus = modv;
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Extreme keys, collisions at the home slot, duplicate insert, hit and miss.
  task automatic test_directed_keys();
    write_geometry(7'd11, 7'd11);
    offer_request(REQ_INSERT, '0);
    offer_request(REQ_INSERT, KEY_MAX);
    offer_request(REQ_INSERT, KEY_W'(11));
    offer_request(REQ_INSERT, '0);
    offer_request(REQ_FIND, '0);
    offer_request(REQ_FIND, KEY_MAX);
    offer_request(REQ_FIND, KEY_W'(11));
    offer_request(REQ_FIND, KEY_W'(22));
    offer_request(REQ_FIND, KEY_W'(5));
    settle_stream();
  endtask

  // Zero length and zero modulus, a modulus above the length, and probing that runs out.
  task automatic test_exhausted_probing();
    write_geometry(7'd0, 7'd0);
    offer_request(REQ_INSERT, KEY_W'(5));
    offer_request(REQ_FIND, KEY_W'(5));
    offer_request(REQ_FIND, '0);
    settle_stream();
    write_geometry(7'd2, 7'd127);
    offer_request(REQ_INSERT, KEY_W'(3));
    offer_request(REQ_FIND, KEY_W'(7));
    settle_stream();
  endtask

  // Length above the table size, long probe walks, and slots left beyond a shorter length.
  task automatic test_length_extremes();
    write_geometry(7'd127, 7'd1);
    offer_request(REQ_INSERT, KEY_W'(100));
    offer_request(REQ_INSERT, KEY_W'(200));
    offer_request(REQ_INSERT, KEY_W'(300));
    offer_request(REQ_INSERT, KEY_W'(400));
    offer_request(REQ_FIND, KEY_W'(400));
    offer_request(REQ_FIND, KEY_W'(999));
    settle_stream();
    write_geometry(7'd64, 7'd64);
    offer_request(REQ_INSERT, KEY_W'(63));
    offer_request(REQ_FIND, KEY_W'(63));
    settle_stream();
    write_geometry(7'd3, 7'd3);
    offer_request(REQ_FIND, KEY_W'(100));
    offer_request(REQ_INSERT, KEY_W'(63));
    settle_stream();
  endtask

  // The result side holds off for a long stretch while requests keep coming.
  task automatic test_output_stall();
    write_geometry(7'd16, 7'd13);
    hold_req <= 1'b1;
    for (int k = 0; k < 12; k++)
      offer_request(($urandom_range(0, 1) == 1) ? REQ_FIND : REQ_INSERT, pick_key());
    settle_stream();
  endtask

  // Random phases, each under its own table setting; the last one runs without idling.
  task automatic test_random_phases();
    logic [CFG_W-1:0] lens [PHASES] = '{7'd64, 7'd13, 7'd1, 7'd127, 7'd32, 7'd0, 7'd50, 7'd64};
    logic [CFG_W-1:0] mods [PHASES] = '{7'd64, 7'd5, 7'd1, 7'd0, 7'd29, 7'd127, 7'd50, 7'd61};
    logic [CFG_W-1:0] len;
    logic [CFG_W-1:0] modv;
    logic             req;
    for (int p = 0; p < PHASES; p++) begin
      len  = lens[p];
      modv = mods[p];
      if (p == PHASES - 2) begin
        len  = CFG_W'($urandom_range(2, TABLE_SIZE));
        modv = CFG_W'($urandom_range(1, len));
      end
      if (p == PHASES - 1) quiet = 1'b1;
      write_geometry(len, modv);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        req = ($urandom_range(0, 99) < 35) ? REQ_INSERT : REQ_FIND;
        offer_request(req, pick_key());
      end
      settle_stream();
    end
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : result_sink
    bit hold_taken;
    hold_taken = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Compare each accepted result item with the oldest expectation.
  always @(posedge clk) begin : result_check
    probe_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result item: status %0d slot %0d count %0d",
               m_axis_tuser, m_axis_tdata[POS_W-1:0], m_axis_tdata[POS_W +: CNT_W]);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, m_axis_tuser);
          mismatch_count++;
        end
        if (m_axis_tdata[POS_W-1:0] !== want.slot) begin
          $error("slot_position: expected %0d actual %0d", want.slot, m_axis_tdata[POS_W-1:0]);
          mismatch_count++;
        end
        if (m_axis_tdata[POS_W +: CNT_W] !== want.count) begin
          $error("probe_count: expected %0d actual %0d", want.count,
                 m_axis_tdata[POS_W +: CNT_W]);
          mismatch_count++;
        end
        status_seen[want.status]++;
      end
    end
  end

  // Watchdog on the whole run.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding.",
             cycle_count, pending_results.size());
    $display("FAIL");
    $finish;
  end

  // Reset, then the tests in turn.
  initial begin : run_tests
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= REQ_INSERT;
    cfg_valid     <= 1'b0;
    cfg_index     <= REG_TABLE_LENGTH;
    cfg_data      <= '0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      slot_used[i] = 1'b0;
      slot_key[i]  = '0;
    end
    mirror_length  = 7'd11;
    mirror_modulus = 7'd11;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_directed_keys();
    test_exhausted_probing();
    test_length_extremes();
    test_output_stall();
    test_random_phases();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d requests under %0d table settings, with a %0d-cycle output hold-off.",
             requests_sent, settings_used, HOLD_CYCLES);
    $display("Results: %0d inserted, %0d full, %0d found, %0d not found.",
             status_seen[ST_INSERTED], status_seen[ST_FULL], status_seen[ST_FOUND],
             status_seen[ST_NOT_FOUND]);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
